// ----- rtl/core/aes_block_encrypt_top_macros.svh -----
// ----------------------------------------------------------------------------
// AES block encrypt assertion macros
// Shared concurrent assertion forms on clk_i / rst_ni.
// ----------------------------------------------------------------------------
`ifndef AES_BLOCK_ENCRYPT_TOP_MACROS_SVH
`define AES_BLOCK_ENCRYPT_TOP_MACROS_SVH

// Same-cycle implication.
`define AES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/aes_enc_pkg.sv -----
// ----------------------------------------------------------------------------
// AES encrypt package
// S-box table and round functions on a 128-bit state, byte 0 in the top bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aes_enc_pkg;

  localparam int unsigned BlockW = 128;
  localparam int unsigned WordW  = 32;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic OpKeyWrite = 1'b0;
  localparam logic OpEncrypt  = 1'b1;

  typedef logic [BlockW-1:0] block_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes then ShiftRows: byte r+4c takes byte r+4((c+r) mod 4).
  function automatic block_t sub_shift(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BlockW-1-8*(r+4*c) -: 8] = SBOX[s[BlockW-1-8*(r+4*((c+r)%4)) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic block_t mix_cols(input block_t s);
    block_t     t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[BlockW-1-32*c -: 8];
      a1 = s[BlockW-9-32*c -: 8];
      a2 = s[BlockW-17-32*c -: 8];
      a3 = s[BlockW-25-32*c -: 8];
      t[BlockW-1-32*c -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[BlockW-9-32*c -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[BlockW-17-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[BlockW-25-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return t;
  endfunction

endpackage

// ----- rtl/core/aes_block_encrypt_top.sv -----
// ----------------------------------------------------------------------------
// AES block encrypt top
// Fully unrolled, one-round-per-stage AES cipher with a loaded key schedule.
// ----------------------------------------------------------------------------
// Load the expanded key schedule one 32-bit word per transfer (opcode 0,
// word 4*r+c is column c of round key r; indexes at or beyond 4*(ROUNDS+1)
// are dropped), then send blocks (opcode 1). The pipeline has ROUNDS+1
// register stages: one stage adds round key 0 and each of the ROUNDS round
// stages does one full round, the last one without MixColumns. A block
// passes through state_q[0] to state_q[ROUNDS] and out_valid_o is the
// valid bit of the last stage. A new block may enter every cycle while
// the output is not stalled, so the sustained rate is one block per
// cycle; each stage holds its block only while the stage after it is full
// and stalled. A key-word transfer is held off until no block is in the
// pipeline, so every block sees exactly the key words written before it.
`timescale 1ns / 1ps

`include "aes_block_encrypt_top_macros.svh"

module aes_block_encrypt_top #(
  parameter int unsigned ROUNDS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [5:0]  key_index_i,
  input  logic [31:0] key_word_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] cipher_high_o,
  output logic [63:0] cipher_low_o
);

  import aes_enc_pkg::*;

  localparam int unsigned Stages   = ROUNDS + 1;
  localparam int unsigned KeyWords = 4 * (ROUNDS + 1);

  // Round keys, each read at its own stage only.
  block_t             rk_q    [Stages];
  block_t             state_q [Stages];
  logic [Stages-1:0]  vld_q;
  logic [Stages:0]    rdy;
  logic               blk_acc;
  logic               key_we;

  // Stage s can take a new block when empty or when its content moves on.
  always_comb begin
    rdy[Stages] = out_ready_i;
    for (int s = Stages - 1; s >= 0; s--) begin
      rdy[s] = !vld_q[s] || rdy[s+1];
    end
  end

  // Key writes wait for an empty pipeline.
  assign in_ready_o = (opcode_i == OpEncrypt) ? rdy[0] : (vld_q == '0);
  assign blk_acc    = in_valid_i && in_ready_o && (opcode_i == OpEncrypt);
  assign key_we     = in_valid_i && in_ready_o && (opcode_i == OpKeyWrite)
                      && (7'(key_index_i) < 7'(KeyWords));

  // Store one key word into its column of its round key.
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < Stages; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (key_we && key_index_i == 6'(4*r + c)) begin
          rk_q[r][BlockW-1-WordW*c -: WordW] <= key_word_i;
        end
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= blk_acc;
      for (int s = 1; s < Stages; s++) begin
        if (rdy[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  // Initial key addition.
  always_ff @(posedge clk_i) begin
    if (blk_acc) begin
      state_q[0] <= {block_high_i, block_low_i} ^ rk_q[0];
    end
  end

  // One round per stage; the last stage skips MixColumns.
  for (genvar s = 1; s < Stages; s++) begin : g_round
    block_t sub_d;
    block_t nxt_d;
    assign sub_d = sub_shift(state_q[s-1]);
    assign nxt_d = ((s == Stages - 1) ? sub_d : mix_cols(sub_d)) ^ rk_q[s];
    always_ff @(posedge clk_i) begin
      if (rdy[s] && vld_q[s-1]) begin
        state_q[s] <= nxt_d;
      end
    end
  end

  assign out_valid_o   = vld_q[Stages-1];
  assign cipher_high_o = state_q[Stages-1][BlockW-1 -: 64];
  assign cipher_low_o  = state_q[Stages-1][63:0];

  `AES_ASSERT_NOW(a_key_when_empty, in_valid_i && in_ready_o && (opcode_i == OpKeyWrite),
    vld_q == '0, "key word written while blocks in flight")
  `AES_ASSERT_NEXT(a_block_enters, blk_acc, vld_q[0], "accepted block lost at entry")
  `AES_ASSERT_NOW(a_block_stall, in_valid_i && (opcode_i == OpEncrypt) && !in_ready_o,
    vld_q[0] && !rdy[1], "block refused while entry stage free")

endmodule

// ----- tb/tb_aes_block_encrypt_top.sv -----
// ----------------------------------------------------------------------------
// AES block encrypt testbench
// Loads key schedules, sends blocks under random idling and a long output
// stall, and checks each ciphertext against an in-bench cipher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_aes_block_encrypt_top;
  import aes_enc_pkg::*;

  localparam int unsigned Rounds   = 10;
  localparam int unsigned KeyWords = 4 * (Rounds + 1);
  localparam int unsigned StallMax = 2000;
  localparam int unsigned Latency  = Rounds + 1;

  // Key, plaintext and ciphertext of the FIPS-197 appendix example (key 000102..0f).
  localparam logic [127:0] FipsKey  = 128'h000102030405060708090a0b0c0d0e0f;
  localparam logic [127:0] FipsPt   = 128'h00112233445566778899aabbccddeeff;
  localparam logic [127:0] FipsCt   = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        opcode_i = OpKeyWrite;
  logic [5:0]  key_index_i = '0;
  logic [31:0] key_word_i = '0;
  logic [63:0] block_high_i = '0;
  logic [63:0] block_low_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] cipher_high_o;
  logic [63:0] cipher_low_o;

  aes_block_encrypt_top #(.ROUNDS(Rounds)) dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_t;

  logic [31:0] sched [KeyWords];
  cipher_t     cipher_q [$];
  int          errors = 0;
  int          blocks_sent = 0;
  int          keys_sent = 0;
  int          cipher_seen = 0;
  int          send_idle = 0;   // percent of cycles the sender idles
  int          recv_idle = 0;   // percent of cycles the receiver stalls
  bit          hold_off = 1'b0;
  int          quiet = 0;

  // ---- in-bench cipher, bytes kept as an array, byte 0 first ----
  function automatic logic [7:0] dbl(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic cipher_t aes_encrypt(logic [63:0] hi, logic [63:0] lo);
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] a0, a1, a2, a3;
    logic [31:0] w;
    cipher_t res;
    for (int i = 0; i < 8; i++) begin
      st[i]   = hi[63-8*i -: 8];
      st[i+8] = lo[63-8*i -: 8];
    end
    for (int rnd = 0; rnd <= Rounds; rnd++) begin
      if (rnd > 0) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            tmp[r+4*c] = SBOX[st[r+4*((c+r)%4)]];
        st = tmp;
        if (rnd < Rounds) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
            st[4*c]   = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
            st[4*c+1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
            st[4*c+2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
            st[4*c+3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
          end
        end
      end
      for (int c = 0; c < 4; c++) begin
        w = sched[4*rnd+c];
        for (int r = 0; r < 4; r++) st[r+4*c] ^= w[31-8*r -: 8];
      end
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63-8*i -: 8] = st[i];
      res.lo[63-8*i -: 8] = st[i+8];
    end
    return res;
  endfunction

  // Standard key expansion, used only to build realistic schedules.
  function automatic void expand_key(logic [127:0] k, ref logic [31:0] ks [KeyWords]);
    logic [31:0] t;
    logic [7:0]  rcon;
    rcon = 8'h01;
    for (int i = 0; i < 4; i++) ks[i] = k[127-32*i -: 32];
    for (int i = 4; i < KeyWords; i++) begin
      t = ks[i-1];
      if (i % 4 == 0) begin
        t = {SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]], SBOX[t[31:24]]};
        t[31:24] ^= rcon;
        rcon = dbl(rcon);
      end
      ks[i] = ks[i-4] ^ t;
    end
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  // ---- driving ----
  task automatic idle_gap();
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Offer one item and hold it until the transfer; valid stays high after.
  task automatic offer(logic op, logic [5:0] idx, logic [31:0] kw,
                       logic [63:0] bh, logic [63:0] bl);
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    key_index_i  <= idx;
    key_word_i   <= kw;
    block_high_i <= bh;
    block_low_i  <= bl;
    do @(posedge clk_i); while (!in_ready_o);
    // Update the predictor at the transfer; blocks enqueue in order.
    if (op == OpKeyWrite) begin
      if (idx < KeyWords) sched[idx] = kw;
      keys_sent++;
    end else begin
      cipher_q.push_back(aes_encrypt(bh, bl));
      blocks_sent++;
    end
  endtask

  task automatic send_key(logic [5:0] idx, logic [31:0] kw);
    idle_gap();
    offer(OpKeyWrite, idx, kw, 64'($urandom) << 32 | $urandom, {$urandom, $urandom});
  endtask

  task automatic send_block(logic [63:0] bh, logic [63:0] bl);
    idle_gap();
    offer(OpEncrypt, 6'($urandom), $urandom, bh, bl);
  endtask

  task automatic load_schedule(logic [127:0] k);
    logic [31:0] ks [KeyWords];
    expand_key(k, ks);
    for (int i = 0; i < KeyWords; i++) send_key(6'(i), ks[i]);
  endtask

  task automatic send_random_block();
    send_block({$urandom, $urandom}, {$urandom, $urandom});
  endtask

  // ---- receiving and checking ----
  always @(posedge clk_i) begin
    cipher_t want;
    if (out_valid_o && out_ready_i) begin
      cipher_seen++;
      if (cipher_q.size() == 0) begin
        report("unexpected cipher_high", cipher_high_o, 64'h0);
      end else begin
        want = cipher_q.pop_front();
        if (cipher_high_o !== want.hi) report("cipher_high", cipher_high_o, want.hi);
        if (cipher_low_o !== want.lo) report("cipher_low", cipher_low_o, want.lo);
      end
    end
    out_ready_i <= !hold_off && !(recv_idle > 0 && $urandom_range(99) < recv_idle);
  end

  // Watchdog: end the run after a long stretch with no transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > StallMax * 4) begin
      $display("watchdog expired");
      $display("tb: failure");
      $finish;
    end
  end

  // Directed rows: opcode, key index, key word, block, expected (if known).
  typedef struct {
    logic         op;
    logic [5:0]   idx;
    logic [31:0]  kw;
    logic [127:0] blk;
    bit           known;
    logic [127:0] ct;
  } row_t;

  row_t rows [$];

  task automatic wait_drain();
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic run_phase(int n, int si, int ri);
    send_idle = si;
    recv_idle = ri;
    for (int i = 0; i < n; i++) begin
      // Mostly blocks; some key rewrites with fresh words, some dropped writes.
      case ($urandom_range(19))
        0: send_key(6'($urandom_range(63, KeyWords)), $urandom);
        1: send_key(6'($urandom_range(KeyWords - 1)), $urandom);
        default: send_random_block();
      endcase
    end
  endtask

  initial begin
    logic [31:0] zero_ks [KeyWords];
    for (int i = 0; i < KeyWords; i++) sched[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: FIPS example, extreme words, dropped out-of-range index.
    expand_key(FipsKey, zero_ks);
    for (int i = 0; i < KeyWords; i++)
      rows.push_back('{OpKeyWrite, 6'(i), zero_ks[i], '0, 1'b0, '0});
    rows.push_back('{OpEncrypt, 6'h3f, 32'hffffffff, FipsPt, 1'b1, FipsCt});
    rows.push_back('{OpKeyWrite, 6'd63, 32'hffffffff, '1, 1'b0, '0});
    rows.push_back('{OpKeyWrite, 6'(KeyWords), 32'h0, '0, 1'b0, '0});
    rows.push_back('{OpEncrypt, 6'h0, 32'h0, FipsPt, 1'b1, FipsCt});
    rows.push_back('{OpEncrypt, 6'h0, 32'h0, '0, 1'b0, '0});
    rows.push_back('{OpEncrypt, 6'h2a, 32'h5555aaaa, '1, 1'b0, '0});
    rows.push_back('{OpKeyWrite, 6'd0, 32'hffffffff, '0, 1'b0, '0});
    rows.push_back('{OpKeyWrite, 6'(KeyWords - 1), 32'h0, '1, 1'b0, '0});
    rows.push_back('{OpEncrypt, 6'h15, 32'haaaa5555, 128'h8000_0000_0000_0000_0000_0000_0000_0001,
                     1'b0, '0});
    foreach (rows[i]) begin
      offer(rows[i].op, rows[i].idx, rows[i].kw, rows[i].blk[127:64], rows[i].blk[63:0]);
      if (rows[i].known) begin
        if (cipher_q[$].hi !== rows[i].ct[127:64])
          report("known row cipher_high", cipher_q[$].hi, rows[i].ct[127:64]);
        if (cipher_q[$].lo !== rows[i].ct[63:0])
          report("known row cipher_low", cipher_q[$].lo, rows[i].ct[63:0]);
      end
    end

    // Random part over idling phases.
    run_phase(220, 0, 0);
    load_schedule({$urandom, $urandom, $urandom, $urandom});
    run_phase(220, 64, 0);
    load_schedule('1);
    run_phase(220, 0, 64);
    load_schedule('0);
    run_phase(220, 10, 10);

    // Long output stall: keep offering so the pipeline fills and stalls input.
    send_idle = 0;
    recv_idle = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 60; i++) send_random_block();
    join
    run_phase(200, 30, 30);

    in_valid_i <= 1'b0;
    wait_drain();
    $display("covered %0d blocks and %0d key writes, %0d ciphertexts checked",
             blocks_sent, keys_sent, cipher_seen);
    $display("idling phases none, sender, receiver, both, plus a long output stall");
    if (errors == 0 && cipher_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
